### rtl/rfe_pkg.sv
// Shared types, screen geometry and codes for the rectangle fill engine.
// Depends on nothing; the engine top, the interfaces and the bench take names from here by scope.
package rfe_pkg;

    localparam int unsigned SCREEN_WIDTH  = 320;
    localparam int unsigned SCREEN_HEIGHT = 200;
    localparam int unsigned COORD_W       = 9;
    localparam int unsigned COLOR_W       = 8;
    localparam int unsigned STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    localparam coord_t SCREEN_W_C = coord_t'(SCREEN_WIDTH);
    localparam coord_t SCREEN_H_C = coord_t'(SCREEN_HEIGHT);
    localparam addr_t  ROW_STRIDE = addr_t'(SCREEN_WIDTH);

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_READ = 5'b00100,
        ST_CAPT = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

endpackage

### rtl/rfe_req_if.sv
// Request channel of the rectangle fill engine: one fill or read word.
// Depends on rfe_pkg for coordinate and color types.
interface rfe_req_if;
    logic            valid;
    logic            ready;
    logic            op;
    rfe_pkg::coord_t x_left;
    rfe_pkg::coord_t x_right;
    rfe_pkg::coord_t y_top;
    rfe_pkg::coord_t y_bottom;
    rfe_pkg::color_t fill_color;

    modport source (output valid, op, x_left, x_right, y_top, y_bottom, fill_color,
                    input ready);
    modport sink (input valid, op, x_left, x_right, y_top, y_bottom, fill_color,
                  output ready);
endinterface

### rtl/rfe_rsp_if.sv
// Response channel of the rectangle fill engine: status and pixel word.
// Depends on rfe_pkg for the color type.
interface rfe_rsp_if;
    logic            valid;
    logic            ready;
    logic            status;
    rfe_pkg::color_t pixel_value;

    modport source (output valid, status, pixel_value, input ready);
    modport sink (input valid, status, pixel_value, output ready);
endinterface

### rtl/rectangle_fill_engine_top.sv
// Rectangle fill engine: 320x200 frame store of 8-bit pixels with fill and read.
// Depends on rfe_pkg, rfe_req_if, rfe_rsp_if and rfe_ram.
//
// Usage:
//   req carries one word per item: op 0 fills the inclusive rectangle
//   x_left..x_right by y_top..y_bottom with fill_color; op 1 reads the pixel
//   at (x_left, y_top). rsp returns one word per item: status 0 when done,
//   1 when a coordinate is off screen or the rectangle is inverted; pixel_value
//   holds the pixel for a read and zero otherwise.
//   The block works on one item at a time; req.ready is high only while idle.
//   From acceptance to response valid: a fill writes one pixel per
//   cycle through the single RAM write port, width*height pixels in all
//   (64000 for a full screen); a read goes through ST_READ (RAM read) and
//   ST_CAPT (capture); a rejected item goes to ST_RESP. The block is idle
//   again, and takes the next word, in the cycle after the response is taken.
//   The response word is held in registers until rsp.ready is high; a stalled
//   receiver holds the block and the frame store unchanged.
//   Reset clears the control state only. The frame store is undefined after
//   reset; fill the whole screen once before reading.
module rectangle_fill_engine_top (
    input logic      clk,
    input logic      rst_n,
    rfe_req_if.sink  req,
    rfe_rsp_if.source rsp
);

    rfe_pkg::state_t state_reg, state_next;
    rfe_pkg::coord_t col_reg, col_next;
    rfe_pkg::coord_t row_reg, row_next;
    rfe_pkg::coord_t left_reg, left_next;
    rfe_pkg::coord_t right_reg, right_next;
    rfe_pkg::coord_t bottom_reg, bottom_next;
    rfe_pkg::color_t color_reg, color_next;
    rfe_pkg::addr_t  addr_reg, addr_next;
    rfe_pkg::addr_t  row_addr_reg, row_addr_next;
    logic            status_reg, status_next;
    rfe_pkg::color_t pixel_reg, pixel_next;

    rfe_pkg::color_t ram_rd_data;
    rfe_pkg::addr_t  start_addr;
    logic            accept;
    logic            read_ok;
    logic            fill_ok;
    logic            last_col;
    logic            last_row;

    assign accept = req.valid && req.ready;

    assign read_ok = (req.x_left < rfe_pkg::SCREEN_W_C) && (req.y_top < rfe_pkg::SCREEN_H_C);

    assign fill_ok = read_ok
                     && (req.x_right < rfe_pkg::SCREEN_W_C)
                     && (req.y_bottom < rfe_pkg::SCREEN_H_C)
                     && (req.x_left <= req.x_right)
                     && (req.y_top <= req.y_bottom);

    assign start_addr = rfe_pkg::addr_t'(rfe_pkg::addr_t'(req.y_top) * rfe_pkg::ROW_STRIDE)
                        + rfe_pkg::addr_t'(req.x_left);

    assign last_col = (col_reg == right_reg);
    assign last_row = (row_reg == bottom_reg);

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        bottom_next   = bottom_reg;
        color_next    = color_reg;
        addr_next     = addr_reg;
        row_addr_next = row_addr_reg;
        status_next   = status_reg;
        pixel_next    = pixel_reg;

        unique case (state_reg)
            rfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    col_next      = req.x_left;
                    row_next      = req.y_top;
                    left_next     = req.x_left;
                    right_next    = req.x_right;
                    bottom_next   = req.y_bottom;
                    color_next    = req.fill_color;
                    addr_next     = start_addr;
                    row_addr_next = start_addr;
                    status_next   = rfe_pkg::STATUS_DONE;
                    pixel_next    = '0;
                    if (req.op == rfe_pkg::OP_READ)
                    begin
                        if (read_ok)
                        begin
                            state_next = rfe_pkg::ST_READ;
                        end
                        else
                        begin
                            status_next = rfe_pkg::STATUS_REJECT;
                            state_next  = rfe_pkg::ST_RESP;
                        end
                    end
                    else
                    begin
                        if (fill_ok)
                        begin
                            state_next = rfe_pkg::ST_FILL;
                        end
                        else
                        begin
                            status_next = rfe_pkg::STATUS_REJECT;
                            state_next  = rfe_pkg::ST_RESP;
                        end
                    end
                end
            end
            rfe_pkg::ST_FILL:
            begin
                if (last_col)
                begin
                    if (last_row)
                    begin
                        state_next = rfe_pkg::ST_RESP;
                    end
                    else
                    begin
                        col_next      = left_reg;
                        row_next      = row_reg + 1'b1;
                        row_addr_next = row_addr_reg + rfe_pkg::ROW_STRIDE;
                        addr_next     = row_addr_reg + rfe_pkg::ROW_STRIDE;
                    end
                end
                else
                begin
                    col_next  = col_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            rfe_pkg::ST_READ:
            begin
                state_next = rfe_pkg::ST_CAPT;
            end
            rfe_pkg::ST_CAPT:
            begin
                pixel_next = ram_rd_data;
                state_next = rfe_pkg::ST_RESP;
            end
            rfe_pkg::ST_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = rfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        bottom_reg   <= bottom_next;
        color_reg    <= color_next;
        addr_reg     <= addr_next;
        row_addr_reg <= row_addr_next;
        status_reg   <= status_next;
        pixel_reg    <= pixel_next;
    end

    rfe_ram #(
        .WIDTH (rfe_pkg::COLOR_W),
        .DEPTH (rfe_pkg::STORE_DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (state_reg == rfe_pkg::ST_FILL),
        .wr_addr (addr_reg),
        .wr_data (color_reg),
        .rd_en   (state_reg == rfe_pkg::ST_READ),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign req.ready       = (state_reg == rfe_pkg::ST_IDLE);
    assign rsp.valid       = (state_reg == rfe_pkg::ST_RESP);
    assign rsp.status      = status_reg;
    assign rsp.pixel_value = pixel_reg;

`ifndef SYNTHESIS
    a_fill_addr_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfe_pkg::ST_FILL) |->
            (addr_reg == rfe_pkg::addr_t'(rfe_pkg::addr_t'(row_reg) * rfe_pkg::ROW_STRIDE
                                          + rfe_pkg::addr_t'(col_reg))))
        else $error("fill address out of step with row and column");

    a_fill_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfe_pkg::ST_FILL) |->
            (col_reg >= left_reg) && (col_reg <= right_reg) && (row_reg <= bottom_reg))
        else $error("fill walked outside its rectangle");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfe_pkg::ST_FILL) && last_col && last_row |=>
            (state_reg == rfe_pkg::ST_RESP))
        else $error("fill did not end after its last pixel");

    a_capture_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfe_pkg::ST_CAPT) |-> ($past(state_reg) == rfe_pkg::ST_READ))
        else $error("pixel captured without a RAM read");

    a_reject_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == rfe_pkg::STATUS_REJECT) |-> (rsp.pixel_value == '0))
        else $error("rejected word carries a pixel");
`endif

endmodule

### rtl/rfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the frame store.
module rfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### dv/tb_rectangle_fill_engine_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rectangle_fill_engine_top: fill and read words with random idling.
// Depends on rfe_pkg, rfe_req_if, rfe_rsp_if and the engine RTL.
module tb_rectangle_fill_engine_top;

    typedef struct packed {
        logic            op;
        rfe_pkg::coord_t x_left;
        rfe_pkg::coord_t x_right;
        rfe_pkg::coord_t y_top;
        rfe_pkg::coord_t y_bottom;
        rfe_pkg::color_t fill_color;
    } fill_word_t;

    typedef struct packed {
        logic            status;
        rfe_pkg::color_t pixel;
    } answer_t;

    typedef struct packed {
        fill_word_t word;
        logic       typed;
        answer_t    answer;
    } directed_row_t;

    localparam int     N_DIRECTED     = 25;
    localparam int     ITEMS_PER_PASS = 20;
    localparam int     HOLDOFF_CYCLES = 300;
    localparam int     TAIL_CYCLES    = 4;
    localparam longint TIMEOUT_NS     = 20_000_000;
    localparam int     GAP_PCT [4]    = '{0, 50, 0, 33};
    localparam int     STALL_PCT [4]  = '{0, 0, 50, 33};

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd319, 9'd0, 9'd199, 8'hA5}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'hA5}},
        '{'{rfe_pkg::OP_READ, 9'd319, 9'd511, 9'd199, 9'd511, 8'hFF}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'hA5}},
        '{'{rfe_pkg::OP_FILL, 9'd319, 9'd319, 9'd199, 9'd199, 8'hFF}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd319, 9'd0, 9'd199, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'hFF}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd0, 9'd0, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd0, 9'd0, 9'd0, 9'd0, 8'hFF}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd1, 9'd0, 9'd0, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_DONE, 8'hA5}},
        '{'{rfe_pkg::OP_FILL, 9'd320, 9'd320, 9'd0, 9'd0, 8'h11}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd320, 9'd0, 9'd0, 8'h22}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd0, 9'd200, 9'd200, 8'h33}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd0, 9'd0, 9'd200, 8'h44}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd511, 9'd511, 9'd511, 9'd511, 8'hFF}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd10, 9'd9, 9'd0, 9'd0, 8'h55}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd0, 9'd5, 9'd4, 8'h66}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd320, 9'd0, 9'd0, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd0, 9'd0, 9'd200, 9'd0, 8'h00}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd511, 9'd511, 9'd511, 9'd511, 8'hFF}, 1'b1,
          '{rfe_pkg::STATUS_REJECT, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd319, 9'd319, 9'd0, 9'd199, 8'h3C}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd0, 9'd319, 9'd199, 9'd199, 8'hC3}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd319, 9'd0, 9'd0, 9'd0, 8'h00}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd0, 9'd0, 9'd199, 9'd0, 8'h00}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd319, 9'd0, 9'd199, 9'd0, 8'h00}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_FILL, 9'd100, 9'd227, 9'd50, 9'd113, 8'h5A}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}},
        '{'{rfe_pkg::OP_READ, 9'd227, 9'd0, 9'd113, 9'd0, 8'h00}, 1'b0,
          '{rfe_pkg::STATUS_DONE, 8'h00}}
    };

    logic clk = 1'b0;
    logic rst_n;

    rfe_req_if req ();
    rfe_rsp_if rsp ();

    rectangle_fill_engine_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rfe_pkg::color_t frame_image [rfe_pkg::STORE_DEPTH];
    fill_word_t      last_fill = '0;
    answer_t         owed_answers [$];
    int              mismatch_count = 0;
    int              gap_pct = 0;
    int              stall_pct = 0;
    int              holdoff_req = 0;
    int              holdoff_ack = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_rectangle_fill_engine_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic answer_t paint_and_answer(input fill_word_t w);
        answer_t ans;
        ans.status = rfe_pkg::STATUS_DONE;
        ans.pixel  = '0;
        if (w.op == rfe_pkg::OP_READ)
        begin
            if (w.x_left >= rfe_pkg::SCREEN_W_C || w.y_top >= rfe_pkg::SCREEN_H_C)
                ans.status = rfe_pkg::STATUS_REJECT;
            else
                ans.pixel = frame_image[int'(w.y_top) * rfe_pkg::SCREEN_WIDTH
                                        + int'(w.x_left)];
        end
        else if (w.x_left >= rfe_pkg::SCREEN_W_C || w.x_right >= rfe_pkg::SCREEN_W_C ||
                 w.y_top >= rfe_pkg::SCREEN_H_C || w.y_bottom >= rfe_pkg::SCREEN_H_C ||
                 w.x_left > w.x_right || w.y_top > w.y_bottom)
        begin
            ans.status = rfe_pkg::STATUS_REJECT;
        end
        else
        begin
            for (int row = int'(w.y_top); row <= int'(w.y_bottom); row++)
                for (int col = int'(w.x_left); col <= int'(w.x_right); col++)
                    frame_image[row * rfe_pkg::SCREEN_WIDTH + col] = w.fill_color;
            last_fill = w;
        end
        return ans;
    endfunction

    function automatic fill_word_t make_random_word();
        fill_word_t w;
        int         pick;
        int         n_cols;
        int         n_rows;
        w.op         = rfe_pkg::OP_FILL;
        w.x_left     = rfe_pkg::coord_t'($urandom_range(511));
        w.x_right    = rfe_pkg::coord_t'($urandom_range(511));
        w.y_top      = rfe_pkg::coord_t'($urandom_range(511));
        w.y_bottom   = rfe_pkg::coord_t'($urandom_range(511));
        w.fill_color = rfe_pkg::color_t'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
            begin
                n_cols = rfe_pkg::SCREEN_WIDTH;
                n_rows = 1;
            end
            else if (pick == 1)
            begin
                n_cols = 1;
                n_rows = rfe_pkg::SCREEN_HEIGHT;
            end
            else if (pick == 2)
            begin
                n_cols = $urandom_range(32, 1);
                n_rows = $urandom_range(32, 1);
            end
            else
            begin
                n_cols = $urandom_range(16, 1);
                n_rows = $urandom_range(8, 1);
            end
            w.x_left   = rfe_pkg::coord_t'($urandom_range(rfe_pkg::SCREEN_WIDTH - n_cols));
            w.y_top    = rfe_pkg::coord_t'($urandom_range(rfe_pkg::SCREEN_HEIGHT - n_rows));
            w.x_right  = rfe_pkg::coord_t'(int'(w.x_left) + n_cols - 1);
            w.y_bottom = rfe_pkg::coord_t'(int'(w.y_top) + n_rows - 1);
        end
        else if (pick < 80)
        begin
            w.op = rfe_pkg::OP_READ;
            if ($urandom_range(1) == 1)
            begin
                w.x_left = rfe_pkg::coord_t'($urandom_range(last_fill.x_right,
                                                            last_fill.x_left));
                w.y_top  = rfe_pkg::coord_t'($urandom_range(last_fill.y_bottom,
                                                            last_fill.y_top));
            end
            else
            begin
                w.x_left = rfe_pkg::coord_t'($urandom_range(rfe_pkg::SCREEN_WIDTH - 1));
                w.y_top  = rfe_pkg::coord_t'($urandom_range(rfe_pkg::SCREEN_HEIGHT - 1));
            end
        end
        else
        begin
            w.op = $urandom_range(1) ? rfe_pkg::OP_READ : rfe_pkg::OP_FILL;
            case ($urandom_range(4))
                0: w.x_left = rfe_pkg::coord_t'($urandom_range(511, rfe_pkg::SCREEN_WIDTH));
                1: w.y_top  = rfe_pkg::coord_t'($urandom_range(511, rfe_pkg::SCREEN_HEIGHT));
                2:
                begin
                    if (w.op == rfe_pkg::OP_READ)
                        w.x_left = rfe_pkg::coord_t'($urandom_range(511,
                                                                    rfe_pkg::SCREEN_WIDTH));
                    else
                        w.x_right = rfe_pkg::coord_t'($urandom_range(511,
                                                                     rfe_pkg::SCREEN_WIDTH));
                end
                3:
                begin
                    if (w.op == rfe_pkg::OP_READ)
                    begin
                        w.y_top = rfe_pkg::coord_t'($urandom_range(511,
                                                                   rfe_pkg::SCREEN_HEIGHT));
                    end
                    else
                    begin
                        w.x_left  = rfe_pkg::coord_t'($urandom_range(
                                        rfe_pkg::SCREEN_WIDTH - 1, 1));
                        w.x_right = rfe_pkg::coord_t'($urandom_range(int'(w.x_left) - 1));
                    end
                end
                default:
                begin
                    if (w.op == rfe_pkg::OP_READ)
                    begin
                        w.x_left = rfe_pkg::coord_t'($urandom_range(511,
                                                                    rfe_pkg::SCREEN_WIDTH));
                    end
                    else
                    begin
                        w.y_top    = rfe_pkg::coord_t'($urandom_range(
                                         rfe_pkg::SCREEN_HEIGHT - 1, 1));
                        w.y_bottom = rfe_pkg::coord_t'($urandom_range(int'(w.y_top) - 1));
                    end
                end
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input fill_word_t w, input logic typed, input answer_t typed_ans);
        answer_t ans;
        while ($urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= w.op;
        req.x_left     <= w.x_left;
        req.x_right    <= w.x_right;
        req.y_top      <= w.y_top;
        req.y_bottom   <= w.y_bottom;
        req.fill_color <= w.fill_color;
        do
            @(posedge clk);
        while (!req.ready);
        ans = paint_and_answer(w);
        owed_answers.push_back(typed ? typed_ans : ans);
    endtask

    task automatic drain_answers();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_answers.size() != 0);
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req != holdoff_ack)
            begin
                holdoff_ack = holdoff_req;
                rsp.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (owed_answers.size() == 0)
            begin
                report_mismatch($sformatf("response word with nothing owed: status %0b pixel %02h",
                                          rsp.status, rsp.pixel_value));
            end
            else
            begin
                exp_ans = owed_answers.pop_front();
                if (rsp.status !== exp_ans.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              rsp.status, exp_ans.status));
                if (rsp.pixel_value !== exp_ans.pixel)
                    report_mismatch($sformatf("pixel_value %02h, expected %02h",
                                              rsp.pixel_value, exp_ans.pixel));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.op         = rfe_pkg::OP_FILL;
        req.x_left     = '0;
        req.x_right    = '0;
        req.y_top      = '0;
        req.y_bottom   = '0;
        req.fill_color = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].answer);
        drain_answers();

        for (int pass = 0; pass < 4; pass++)
        begin
            gap_pct   = GAP_PCT[pass];
            stall_pct = STALL_PCT[pass];
            for (int k = 0; k < ITEMS_PER_PASS; k++)
            begin
                if (pass == 0 && k == 10)
                    holdoff_req++;
                send_word(make_random_word(), 1'b0, answer_t'('0));
            end
            drain_answers();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_rectangle_fill_engine_top OK");
        else
            $display("tb_rectangle_fill_engine_top NOT OK");
        $finish;
    end

endmodule
